[rtl/core/greedy_change_maker_macros.svh]
// Assertion macros for the greedy change maker checker.
`ifndef GREEDY_CHANGE_MAKER_MACROS_SVH
`define GREEDY_CHANGE_MAKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gcm_pkg.sv]
// Shared constants and codes for the greedy change maker.
package gcm_pkg;

   // Default parameter values
   localparam int MAX_DENOMS_DEFAULT   = 6;
   localparam int AMOUNT_WIDTH_DEFAULT = 16;

   // Fixed field widths
   localparam int SLOT_REGS       = 6;
   localparam int DENOM_WIDTH     = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int STATUS_WIDTH    = 2;
   localparam int DCOUNT_WIDTH    = 3;
   localparam int SLOT_IDX_WIDTH  = 3;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERPAID = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INEXACT   = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_DENOM_COUNT = 3'd0;
   localparam logic [2:0] REG_DENOM_0     = 3'd1;
   localparam logic [2:0] REG_DENOM_1     = 3'd2;
   localparam logic [2:0] REG_DENOM_2     = 3'd3;
   localparam logic [2:0] REG_DENOM_3     = 3'd4;
   localparam logic [2:0] REG_DENOM_4     = 3'd5;
   localparam logic [2:0] REG_DENOM_5     = 3'd6;

endpackage

[rtl/core/gcm_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all denomination slots.
module gcm_div #(
   parameter int AMOUNT_WIDTH = gcm_pkg::AMOUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [AMOUNT_WIDTH-1:0]          dividend,
   input  logic [gcm_pkg::DENOM_WIDTH-1:0]  divisor,
   output logic                             done,
   output logic [AMOUNT_WIDTH-1:0]          quotient,
   output logic [gcm_pkg::DENOM_WIDTH-1:0]  remainder
);
   import gcm_pkg::*;

   localparam int CNT_WIDTH = $clog2(AMOUNT_WIDTH);

   logic                    run_ff,  run_in;
   logic                    done_ff, done_in;
   logic [CNT_WIDTH-1:0]    cnt_ff,  cnt_in;
   logic [AMOUNT_WIDTH-1:0] a_ff,    a_in;
   logic [DENOM_WIDTH-1:0]  r_ff,    r_in;
   logic [DENOM_WIDTH-1:0]  d_ff,    d_in;

   logic [DENOM_WIDTH:0]    trial;
   logic [DENOM_WIDTH:0]    diff;
   logic                    fits;

   // One shift-compare-subtract step
   assign trial = {r_ff, a_ff[AMOUNT_WIDTH-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = (trial >= {1'b0, d_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (load) begin
         run_in = 1'b1;
         cnt_in = CNT_WIDTH'(AMOUNT_WIDTH - 1);
         a_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (run_ff) begin
         // dividend bits shift out the top, quotient bits shift in the bottom
         a_in = {a_ff[AMOUNT_WIDTH-2:0], fits};
         r_in = fits ? diff[DENOM_WIDTH-1:0] : trial[DENOM_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = a_ff;
   assign remainder = r_ff;

endmodule

[rtl/core/greedy_change_maker.sv]
// Greedy change maker: top level with sequencer, registers and result stage.
//
// Usage:
//  - Request: drive req_price and req_paid and raise start; the transaction is
//    taken at a rising edge with start high and busy low. busy stays high
//    until the result is issued.
//  - Result: rsp_valid pulses for one cycle with rsp_status and the six
//    rsp_count_* values; the receiver cannot stall it and must take it then.
//  - Config: APB-style port, register i at byte address 4*i (denom_count,
//    then denom_0..denom_5); write only while idle. Reads return the values.
//  - Sequence: underpaid requests are answered straight from the check
//    state. Otherwise the sequencer walks the used slots in order,
//    fetching and loading each one and dividing the remaining change by
//    it; a slot of value zero is skipped without a division. The single
//    restoring divider works one quotient bit per cycle.
//  - Throughput: one transaction at a time; a new one may be taken in the
//    cycle the result is shown.
//  - Reset: synchronous; denom_count and every denom_i return to 1, the
//    sequencer goes idle and any transaction in flight is dropped.
module greedy_change_maker #(
   parameter int MAX_DENOMS   = gcm_pkg::MAX_DENOMS_DEFAULT,
   parameter int AMOUNT_WIDTH = gcm_pkg::AMOUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [AMOUNT_WIDTH-1:0]             req_price,
   input  logic [AMOUNT_WIDTH-1:0]             req_paid,
   // result channel
   output logic                                rsp_valid,
   output logic [gcm_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [gcm_pkg::COUNT_WIDTH-1:0]     rsp_count_0,
   output logic [gcm_pkg::COUNT_WIDTH-1:0]     rsp_count_1,
   output logic [gcm_pkg::COUNT_WIDTH-1:0]     rsp_count_2,
   output logic [gcm_pkg::COUNT_WIDTH-1:0]     rsp_count_3,
   output logic [gcm_pkg::COUNT_WIDTH-1:0]     rsp_count_4,
   output logic [gcm_pkg::COUNT_WIDTH-1:0]     rsp_count_5,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gcm_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [gcm_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [gcm_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   import gcm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_LOAD   = 5'b01000,
      ST_DIVIDE = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [AMOUNT_WIDTH-1:0]    price_ff, price_in;
   logic [AMOUNT_WIDTH-1:0]    paid_ff,  paid_in;
   logic [AMOUNT_WIDTH-1:0]    rem_ff,   rem_in;
   logic [SLOT_IDX_WIDTH-1:0]  slot_ff,  slot_in;
   logic [DENOM_WIDTH-1:0]     cur_denom_ff, cur_denom_in;
   logic [COUNT_WIDTH-1:0]     counts_ff [SLOT_REGS];
   logic [COUNT_WIDTH-1:0]     counts_in [SLOT_REGS];

   logic                       rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_WIDTH-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]     rsp_count_ff [SLOT_REGS];
   logic [COUNT_WIDTH-1:0]     rsp_count_in [SLOT_REGS];

   logic [DCOUNT_WIDTH-1:0]    denom_count_ff;
   logic [DENOM_WIDTH-1:0]     denom_ff [SLOT_REGS];
   logic [CSR_DATA_WIDTH-1:0]  prdata_ff;

   logic                       div_load;
   logic                       div_done;
   logic [AMOUNT_WIDTH-1:0]    div_quot;
   logic [DENOM_WIDTH-1:0]     div_rem;
   logic [31:0]                quot_ext;
   logic [COUNT_WIDTH-1:0]     quot_sat;
   logic [SLOT_IDX_WIDTH-1:0]  used_slots;
   logic [2:0]                 csr_index;
   logic                       csr_wr;
   logic                       csr_rd_setup;

   // Shared divider
   gcm_div #(
      .AMOUNT_WIDTH (AMOUNT_WIDTH)
   ) u_gcm_div (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (rem_ff),
      .divisor   (cur_denom_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Count saturates to the 16-bit field
   assign quot_ext = 32'(div_quot);
   assign quot_sat = (|quot_ext[31:COUNT_WIDTH]) ? '1 : quot_ext[COUNT_WIDTH-1:0];

   // Slot count limited to the build's slot maximum
   assign used_slots = (denom_count_ff > DCOUNT_WIDTH'(MAX_DENOMS)) ?
                       SLOT_IDX_WIDTH'(MAX_DENOMS) : denom_count_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      price_in      = price_ff;
      paid_in       = paid_ff;
      rem_in        = rem_ff;
      slot_in       = slot_ff;
      cur_denom_in  = cur_denom_ff;
      counts_in     = counts_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      div_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               price_in = req_price;
               paid_in  = req_paid;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            slot_in = '0;
            for (int j = 0; j < SLOT_REGS; j++) begin
               counts_in[j] = '0;
            end
            if (paid_ff < price_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_UNDERPAID;
               for (int j = 0; j < SLOT_REGS; j++) begin
                  rsp_count_in[j] = '0;
               end
               state_in = ST_IDLE;
            end else begin
               rem_in   = paid_ff - price_ff;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (slot_ff == used_slots) begin
               // all slots walked: anything left means no exact change
               rsp_valid_in = 1'b1;
               if (rem_ff == '0) begin
                  rsp_status_in = STATUS_OK;
                  rsp_count_in  = counts_ff;
               end else begin
                  rsp_status_in = STATUS_INEXACT;
                  for (int j = 0; j < SLOT_REGS; j++) begin
                     rsp_count_in[j] = '0;
                  end
               end
               state_in = ST_IDLE;
            end else begin
               cur_denom_in = denom_ff[slot_ff];
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // zero-valued slot is skipped
            if (cur_denom_ff == '0) begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_FETCH;
            end else begin
               div_load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               counts_in[slot_ff] = quot_sat;
               rem_in             = AMOUNT_WIDTH'(div_rem);
               slot_in            = slot_ff + 1'b1;
               state_in           = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result payload, no reset
   always_ff @(posedge clock) begin
      price_ff      <= price_in;
      paid_ff       <= paid_in;
      rem_ff        <= rem_in;
      slot_ff       <= slot_in;
      cur_denom_ff  <= cur_denom_in;
      counts_ff     <= counts_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Configuration registers
   assign csr_index    = paddr[4:2];
   assign csr_wr       = psel && penable && pwrite;
   assign csr_rd_setup = psel && !penable && !pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         denom_count_ff <= DCOUNT_WIDTH'(1);
         for (int j = 0; j < SLOT_REGS; j++) begin
            denom_ff[j] <= DENOM_WIDTH'(1);
         end
      end else if (csr_wr) begin
         case (csr_index)
            REG_DENOM_COUNT: denom_count_ff <= pwdata[DCOUNT_WIDTH-1:0];
            REG_DENOM_0:     denom_ff[0]    <= pwdata[DENOM_WIDTH-1:0];
            REG_DENOM_1:     denom_ff[1]    <= pwdata[DENOM_WIDTH-1:0];
            REG_DENOM_2:     denom_ff[2]    <= pwdata[DENOM_WIDTH-1:0];
            REG_DENOM_3:     denom_ff[3]    <= pwdata[DENOM_WIDTH-1:0];
            REG_DENOM_4:     denom_ff[4]    <= pwdata[DENOM_WIDTH-1:0];
            REG_DENOM_5:     denom_ff[5]    <= pwdata[DENOM_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read data captured in the setup cycle
   always_ff @(posedge clock) begin
      if (csr_rd_setup) begin
         case (csr_index)
            REG_DENOM_COUNT: prdata_ff <= CSR_DATA_WIDTH'(denom_count_ff);
            REG_DENOM_0:     prdata_ff <= CSR_DATA_WIDTH'(denom_ff[0]);
            REG_DENOM_1:     prdata_ff <= CSR_DATA_WIDTH'(denom_ff[1]);
            REG_DENOM_2:     prdata_ff <= CSR_DATA_WIDTH'(denom_ff[2]);
            REG_DENOM_3:     prdata_ff <= CSR_DATA_WIDTH'(denom_ff[3]);
            REG_DENOM_4:     prdata_ff <= CSR_DATA_WIDTH'(denom_ff[4]);
            REG_DENOM_5:     prdata_ff <= CSR_DATA_WIDTH'(denom_ff[5]);
            default:         prdata_ff <= '0;
         endcase
      end
   end

   // Outputs
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count_0 = rsp_count_ff[0];
   assign rsp_count_1 = rsp_count_ff[1];
   assign rsp_count_2 = rsp_count_ff[2];
   assign rsp_count_3 = rsp_count_ff[3];
   assign rsp_count_4 = rsp_count_ff[4];
   assign rsp_count_5 = rsp_count_ff[5];
   assign prdata      = prdata_ff;
   assign pready      = 1'b1;

endmodule

[rtl/core/gcm_checker.sv]
// Port-level checks for the greedy change maker, bound to the top level.
`include "greedy_change_maker_macros.svh"

module gcm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              rsp_valid,
   input  logic [gcm_pkg::STATUS_WIDTH-1:0]  rsp_status,
   input  logic [gcm_pkg::COUNT_WIDTH-1:0]   rsp_count_0,
   input  logic [gcm_pkg::COUNT_WIDTH-1:0]   rsp_count_1,
   input  logic [gcm_pkg::COUNT_WIDTH-1:0]   rsp_count_2,
   input  logic [gcm_pkg::COUNT_WIDTH-1:0]   rsp_count_3,
   input  logic [gcm_pkg::COUNT_WIDTH-1:0]   rsp_count_4,
   input  logic [gcm_pkg::COUNT_WIDTH-1:0]   rsp_count_5
);
   import gcm_pkg::*;

   logic accept;
   logic counts_zero;

   assign accept      = start && !busy;
   assign counts_zero = (rsp_count_0 == '0) && (rsp_count_1 == '0) &&
                        (rsp_count_2 == '0) && (rsp_count_3 == '0) &&
                        (rsp_count_4 == '0) && (rsp_count_5 == '0);

   // an accepted transaction makes the block busy
   `GCM_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy not raised after accept")

   // a result is a single-cycle strobe
   `GCM_ASSERT_NEXT(a_valid_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")

   // a result ends a busy period
   `GCM_ASSERT_SAME(a_valid_ends_busy, clock, reset, rsp_valid, !busy && $past(busy), "result without preceding busy period")

   // error results carry no coins
   `GCM_ASSERT_SAME(a_error_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), counts_zero, "error result with nonzero counts")

endmodule

bind greedy_change_maker gcm_checker u_gcm_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_status  (rsp_status),
   .rsp_count_0 (rsp_count_0),
   .rsp_count_1 (rsp_count_1),
   .rsp_count_2 (rsp_count_2),
   .rsp_count_3 (rsp_count_3),
   .rsp_count_4 (rsp_count_4),
   .rsp_count_5 (rsp_count_5)
);

[verif/greedy_change_maker_test.sv]
// Self-checking testbench for the greedy change maker: directed script, then random transactions.
`timescale 1ns / 1ps

module greedy_change_maker_test;
   import gcm_pkg::*;

   // Register index with nothing behind it; writes there must be dropped
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]                 status;
      logic [SLOT_REGS-1:0][COUNT_WIDTH-1:0]   count;
   } change_type;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic [2:0]    reg_idx;
      logic [31:0]   data;
      logic [15:0]   price;
      logic [15:0]   paid;
      bit            typed;
      change_type    want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_price = '0;
   logic [15:0] req_paid = '0;
   logic rsp_valid;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [COUNT_WIDTH-1:0] rsp_count_0, rsp_count_1, rsp_count_2;
   logic [COUNT_WIDTH-1:0] rsp_count_3, rsp_count_4, rsp_count_5;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   // Shadow of the configuration registers
   logic [2:0]  slot_count = 3'd1;
   logic [15:0] denom_val [SLOT_REGS] = '{default: 16'd1};

   change_type     pending_change [$];
   change_type     staged_change;
   script_row_type script [$];
   int             error_count = 0;
   int             send_idle = 0;

   greedy_change_maker i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_price   (req_price),
      .req_paid    (req_paid),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_count_0 (rsp_count_0),
      .rsp_count_1 (rsp_count_1),
      .rsp_count_2 (rsp_count_2),
      .rsp_count_3 (rsp_count_3),
      .rsp_count_4 (rsp_count_4),
      .rsp_count_5 (rsp_count_5),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Greedy change over the configured slots, in slot order
   function automatic change_type make_change(input logic [15:0] price,
                                              input logic [15:0] paid);
      change_type  res;
      logic [15:0] rest;
      int          used;
      int          i;
      res = '0;
      if (paid < price) begin
         res.status = STATUS_UNDERPAID;
         return res;
      end
      used = (slot_count > MAX_DENOMS_DEFAULT) ? MAX_DENOMS_DEFAULT : int'(slot_count);
      rest = paid - price;
      // quotients of 16-bit amounts always fit a count, no saturation needed
      for (i = 0; i < used; i++) begin
         if (denom_val[i] != 16'd0) begin
            res.count[i] = rest / denom_val[i];
            rest = rest % denom_val[i];
         end
      end
      if (rest != 16'd0) begin
         res = '0;
         res.status = STATUS_INEXACT;
      end else begin
         res.status = STATUS_OK;
      end
      return res;
   endfunction

   function automatic logic [31:0] reg_value(input logic [2:0] idx);
      if (idx == REG_DENOM_COUNT) begin
         return {29'd0, slot_count};
      end
      return {16'd0, denom_val[idx - REG_DENOM_0]};
   endfunction

   // Accept transactions and check results against the oldest expectation
   always @(posedge clock) begin : check_results
      change_type want;
      change_type seen;
      if (!reset && start && !busy) begin
         pending_change.insert(pending_change.size(), staged_change);
      end
      if (!reset && rsp_valid) begin
         seen.status = rsp_status;
         seen.count = {rsp_count_5, rsp_count_4, rsp_count_3,
                       rsp_count_2, rsp_count_1, rsp_count_0};
         if (pending_change.size() == 0) begin
            $display("%0t: result expected none, got status %0d", $time, rsp_status);
            error_count++;
         end else begin
            want = pending_change.pop_front();
            if (seen.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, seen.status);
               error_count++;
            end
            for (int i = 0; i < SLOT_REGS; i++) begin
               if (seen.count[i] !== want.count[i]) begin
                  $display("%0t: count_%0d expected %0d, got %0d",
                           $time, i, want.count[i], seen.count[i]);
                  error_count++;
               end
            end
         end
      end
   end

   // Called at a falling edge; returns at a falling edge
   task automatic issue(input logic [15:0] price, input logic [15:0] paid,
                        input change_type want);
      if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
         repeat ($urandom_range(1, 140)) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      staged_change = want;
      start <= 1'b1;
      req_price <= price;
      req_paid <= paid;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle;
      start <= 1'b0;
      while (pending_change.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Read a register back and compare with the shadow
   task automatic csr_check(input logic [2:0] idx);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== reg_value(idx)) begin
         $display("%0t: register %0d expected %0h, got %0h", $time, idx, reg_value(idx), prdata);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_DENOM_COUNT) begin
         slot_count = data[2:0];
      end else if (idx >= REG_DENOM_0 && idx <= REG_DENOM_5) begin
         denom_val[idx - REG_DENOM_0] = data[15:0];
      end
      if (idx != REG_UNMAPPED) begin
         csr_check(idx);
      end
   endtask

   task automatic add_item(input logic [15:0] price, input logic [15:0] paid);
      script_row_type row;
      row = '{kind: ROW_ITEM, reg_idx: '0, data: '0, price: price, paid: paid,
              typed: 1'b0, want: '0};
      script.insert(script.size(), row);
   endtask

   task automatic add_checked(input logic [15:0] price, input logic [15:0] paid,
                              input logic [STATUS_WIDTH-1:0] status,
                              input logic [15:0] count0);
      script_row_type row;
      row = '{kind: ROW_ITEM, reg_idx: '0, data: '0, price: price, paid: paid,
              typed: 1'b1, want: '0};
      row.want.status = status;
      row.want.count[0] = count0;
      script.insert(script.size(), row);
   endtask

   task automatic add_write(input logic [2:0] idx, input logic [31:0] data);
      script_row_type row;
      row = '{kind: ROW_WRITE, reg_idx: idx, data: data, price: '0, paid: '0,
              typed: 1'b0, want: '0};
      script.insert(script.size(), row);
   endtask

   function automatic logic [15:0] pick_denom;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'd0;
      if (r == 1) return 16'hFFFF;
      if (r == 2) return 16'd1;
      if (r < 6) return 16'($urandom_range(1, 65535));
      return 16'($urandom_range(1, 200));
   endfunction

   // New random register settings; upper data bits carry noise
   task automatic apply_random_settings;
      logic [31:0] data;
      int          r;
      wait_idle();
      r = $urandom_range(0, 9);
      data = $urandom();
      data[2:0] = (r == 0) ? 3'd0 : (r == 1) ? 3'd7 : 3'($urandom_range(1, 6));
      csr_write(REG_DENOM_COUNT, data);
      for (int i = 0; i < SLOT_REGS; i++) begin
         data = $urandom();
         data[15:0] = pick_denom();
         csr_write(3'(REG_DENOM_0 + i), data);
      end
      if ($urandom_range(0, 3) == 0) begin
         csr_write(REG_UNMAPPED, $urandom());
      end
   endtask

   // Mostly payments whose change is built from the configured slots
   task automatic send_random_item;
      int change;
      int used;
      int k;
      int pr;
      int pd;
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         pd = $urandom_range(0, 65534);
         pr = $urandom_range(pd + 1, 65535);
      end else if (r < 20) begin
         pr = $urandom_range(0, 65535);
         pd = $urandom_range(0, 65535);
      end else begin
         change = 0;
         used = (slot_count > MAX_DENOMS_DEFAULT) ? MAX_DENOMS_DEFAULT : int'(slot_count);
         for (int i = 0; i < used; i++) begin
            if (denom_val[i] != 16'd0) begin
               k = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 40 : 3);
               if (change + k * int'(denom_val[i]) <= 65535) begin
                  change += k * int'(denom_val[i]);
               end
            end
         end
         pr = $urandom_range(0, 65535 - change);
         pd = pr + change;
      end
      issue(16'(pr), 16'(pd), make_change(16'(pr), 16'(pd)));
   endtask

   initial begin
      int idle_plan [3];
      idle_plan = '{27, 74, 0};

      // Directed script: extremes after reset, then each special case
      add_checked(16'd0, 16'd0, STATUS_OK, 16'd0);
      add_checked(16'd0, 16'hFFFF, STATUS_OK, 16'hFFFF);
      add_checked(16'hFFFF, 16'd0, STATUS_UNDERPAID, 16'd0);
      add_checked(16'hFFFF, 16'hFFFF, STATUS_OK, 16'd0);
      add_checked(16'd1, 16'd0, STATUS_UNDERPAID, 16'd0);
      // unsorted slot values
      add_write(REG_DENOM_COUNT, 32'd6);
      add_write(REG_DENOM_0, 32'd50);
      add_write(REG_DENOM_1, 32'd20);
      add_write(REG_DENOM_2, 32'd100);
      add_write(REG_DENOM_3, 32'd5);
      add_write(REG_DENOM_4, 32'd10);
      add_write(REG_DENOM_5, 32'd1);
      add_item(16'd37, 16'd500);
      add_item(16'd0, 16'hFFFF);
      add_item(16'd12345, 16'd54321);
      // zero value slot is skipped, change can be left over
      add_write(REG_DENOM_5, 32'd0);
      add_checked(16'd0, 16'd3, STATUS_INEXACT, 16'd0);
      add_item(16'd0, 16'hFFFF);
      // equal values: the later slot gets nothing
      add_write(REG_DENOM_1, 32'd50);
      add_item(16'd10, 16'd110);
      // no slots in use
      add_write(REG_DENOM_COUNT, 32'd0);
      add_checked(16'd5, 16'd5, STATUS_OK, 16'd0);
      add_checked(16'd5, 16'd6, STATUS_INEXACT, 16'd0);
      // slot count above the maximum saturates
      add_write(REG_DENOM_COUNT, 32'd7);
      add_item(16'd0, 16'd1000);
      // only the low bits of the count register matter
      add_write(REG_DENOM_COUNT, 32'hFFFF_FFFA);
      add_write(REG_UNMAPPED, 32'h0000_0001);
      add_item(16'd0, 16'd120);
      // largest slot values
      add_write(REG_DENOM_COUNT, 32'd6);
      for (int i = 0; i < SLOT_REGS; i++) begin
         add_write(3'(REG_DENOM_0 + i), 32'hABCD_FFFF);
      end
      add_checked(16'd0, 16'hFFFF, STATUS_OK, 16'd1);
      add_checked(16'd1, 16'hFFFF, STATUS_INEXACT, 16'd0);
      add_write(REG_DENOM_0, 32'd1);
      add_checked(16'd0, 16'hFFFF, STATUS_OK, 16'hFFFF);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of every register
      for (int r = REG_DENOM_COUNT; r <= REG_DENOM_5; r++) begin
         csr_check(3'(r));
      end

      send_idle = 27;
      foreach (script[n]) begin
         if (script[n].kind == ROW_WRITE) begin
            wait_idle();
            csr_write(script[n].reg_idx, script[n].data);
         end else begin
            issue(script[n].price, script[n].paid,
                  script[n].typed ? script[n].want
                                  : make_change(script[n].price, script[n].paid));
         end
      end

      // Random part in three idling phases
      for (int p = 0; p < 3; p++) begin
         send_idle = idle_plan[p];
         for (int n = 0; n < 600; n++) begin
            if (n % 100 == 0) begin
               apply_random_settings();
            end
            send_random_item();
         end
      end

      wait_idle();
      repeat (130) @(posedge clock);
      if (error_count == 0) begin
         $display("greedy_change_maker verification clean");
      end else begin
         $display("greedy_change_maker verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("greedy_change_maker verification failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/gcm_pkg.sv
rtl/core/gcm_div.sv
rtl/core/greedy_change_maker.sv
rtl/core/gcm_checker.sv
verif/greedy_change_maker_test.sv
